>>> design/phx_pkg.sv
package phx_pkg;

    localparam int unsigned ROUND_COUNT = 10;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned HALF_W      = 64;

    localparam logic [WORD_W-1:0] WEYL_KX = 32'h9E3779B9;
    localparam logic [WORD_W-1:0] WEYL_KY = 32'hBB67AE85;
    localparam logic [WORD_W-1:0] MUL_X   = 32'hD2511F53;
    localparam logic [WORD_W-1:0] MUL_Z   = 32'hCD9E8D57;

    // four working words of one counter block
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] w;
    } t_words;

    // pair of round keys
    typedef struct packed {
        logic [WORD_W-1:0] kx;
        logic [WORD_W-1:0] ky;
    } t_round_key;

    // key offset of a round: round * weyl constant, mod 2^32
    function automatic logic [WORD_W-1:0] round_offset(input int unsigned rnd,
                                                       input logic [WORD_W-1:0] weyl);
        logic [2*WORD_W-1:0] prod;
        prod = (2*WORD_W)'(rnd) * {{WORD_W{1'b0}}, weyl};
        return prod[WORD_W-1:0];
    endfunction

endpackage

>>> design/phx_if.sv
// counter item channel
interface phx_ctr_if;
    logic                        valid;
    logic                        ready;
    logic [phx_pkg::HALF_W-1:0]  counter_low;
    logic [phx_pkg::HALF_W-1:0]  counter_high;

    modport source (output valid, output counter_low, output counter_high, input ready);
    modport sink   (input valid, input counter_low, input counter_high, output ready);
endinterface

// random block channel
interface phx_blk_if;
    logic                        valid;
    logic                        ready;
    logic [phx_pkg::WORD_W-1:0]  word0;
    logic [phx_pkg::WORD_W-1:0]  word1;
    logic [phx_pkg::WORD_W-1:0]  word2;
    logic [phx_pkg::WORD_W-1:0]  word3;

    modport source (output valid, output word0, output word1, output word2, output word3,
                    input ready);
    modport sink   (input valid, input word0, input word1, input word2, input word3,
                    output ready);
endinterface

>>> design/phx_round.sv
module phx_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  phx_pkg::t_words     i_state,
    input  phx_pkg::t_round_key i_key,
    output logic                o_valid,
    output phx_pkg::t_words     o_state
);
    import phx_pkg::*;

    logic [2*WORD_W-1:0] w_px;
    logic [2*WORD_W-1:0] w_pz;
    t_words              n_state;
    t_words              r_state;
    logic                r_valid;

    // two 32x32 products, registered at the end of the stage
    assign w_px = {{WORD_W{1'b0}}, i_state.x} * {{WORD_W{1'b0}}, MUL_X};
    assign w_pz = {{WORD_W{1'b0}}, i_state.z} * {{WORD_W{1'b0}}, MUL_Z};

    always_comb begin
        n_state.x = w_pz[2*WORD_W-1:WORD_W] ^ i_state.y ^ i_key.kx;
        n_state.y = w_pz[WORD_W-1:0];
        n_state.z = w_px[2*WORD_W-1:WORD_W] ^ i_state.w ^ i_key.ky;
        n_state.w = w_px[WORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

>>> design/philox4x32_10_block_generator.sv
// philox4x32-10 counter-based random block generator
//
// i_counter carries one item per handshake: a 128-bit counter as two 64-bit
// halves. o_block returns one item per counter: four 32-bit random words.
// the 64-bit key is written through i_seed_key_we / i_seed_key; the user must
// do so only while the block holds no item, as the block does not enforce it.
// the low half is the first round key, the high half the second.
//
// one pipeline stage per round, two 32x32 multipliers each. an accepted item
// passes through the round registers in order, and one item can enter every
// cycle while o_block.ready keeps the pipe moving. the last round register is
// the output register.
// each stage moves on when it is empty or the stage after it moves, so
// when o_block.ready is low the pipe keeps filling its bubbles and only
// stops taking items once every stage holds one. nothing is dropped or
// repeated across a stall.
// reset (synchronous, active low) empties all stages and clears the key to 0.
module philox4x32_10_block_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_seed_key_we,
    input  logic [phx_pkg::HALF_W-1:0]  i_seed_key,
    phx_ctr_if.sink                     i_counter,
    phx_blk_if.source                   o_block
);
    import phx_pkg::*;

    localparam int unsigned LAST = ROUND_COUNT - 1;

    logic [HALF_W-1:0]           r_key;
    logic [ROUND_COUNT-1:0]      w_valid;   // stage valid bits
    logic [ROUND_COUNT-1:0]      w_adv;     // stage load enables
    t_words                      w_state [ROUND_COUNT];
    t_words                      w_in_state;

    // key register; the user must write it only while the pipe is empty, it is not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_seed_key_we) begin
            r_key <= i_seed_key;
        end
    end

    // split the counter into the four working words
    always_comb begin
        w_in_state.x = i_counter.counter_low[WORD_W-1:0];
        w_in_state.y = i_counter.counter_low[HALF_W-1:WORD_W];
        w_in_state.z = i_counter.counter_high[WORD_W-1:0];
        w_in_state.w = i_counter.counter_high[HALF_W-1:WORD_W];
    end

    // a stage loads when it is empty or its contents move on
    assign w_adv[LAST] = !w_valid[LAST] || o_block.ready;
    genvar g;
    generate
        for (g = 0; g < LAST; g++) begin : g_adv
            assign w_adv[g] = !w_valid[g] || w_adv[g+1];
        end
    endgenerate

    assign i_counter.ready = w_adv[0];

    generate
        for (g = 0; g < ROUND_COUNT; g++) begin : g_round
            t_round_key w_key;
            // round key: base key plus round * weyl constant
            assign w_key.kx = r_key[WORD_W-1:0] + round_offset(g, WEYL_KX);
            assign w_key.ky = r_key[HALF_W-1:WORD_W] + round_offset(g, WEYL_KY);

            if (g == 0) begin : g_first
                phx_round u_round (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (w_adv[g]),
                    .i_valid (i_counter.valid),
                    .i_state (w_in_state),
                    .i_key   (w_key),
                    .o_valid (w_valid[g]),
                    .o_state (w_state[g])
                );
            end else begin : g_next
                phx_round u_round (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (w_adv[g]),
                    .i_valid (w_valid[g-1]),
                    .i_state (w_state[g-1]),
                    .i_key   (w_key),
                    .o_valid (w_valid[g]),
                    .o_state (w_state[g])
                );
            end
        end
    endgenerate

    // last round register drives the result channel
    assign o_block.valid = w_valid[LAST];
    assign o_block.word0 = w_state[LAST].x;
    assign o_block.word1 = w_state[LAST].y;
    assign o_block.word2 = w_state[LAST].z;
    assign o_block.word3 = w_state[LAST].w;

    // an accepted counter lands in the first stage
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_counter.valid && i_counter.ready) |=> w_valid[0])
        else $error("accepted item missing from first stage");

    // an empty first stage always takes an item
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[0] |-> i_counter.ready)
        else $error("input stalled with empty first stage");

    // a full pipe with a stalled output must not take more
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&w_valid) && !o_block.ready) |-> !i_counter.ready)
        else $error("input accepted into a full stalled pipe");

    // a waiting result stays put while stalled
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[LAST] && !o_block.ready) |=> (w_valid[LAST] && $stable(w_state[LAST])))
        else $error("stalled result changed");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_valid == '0))
        else $error("stage valid after reset");

endmodule

>>> tb/philox4x32_10_block_generator_tb.sv
// expected random blocks, predicted from accepted counters and the current key
class philox_block_scoreboard;
    phx_pkg::t_words             expected_blocks[$];
    logic [phx_pkg::HALF_W-1:0]  key_copy = '0;
    int unsigned                 mismatches = 0;
    int unsigned                 counters_seen = 0;
    int unsigned                 blocks_checked = 0;

    function void set_key(input logic [phx_pkg::HALF_W-1:0] k);
        key_copy = k;
    endfunction

    // ten (or ROUND_COUNT) philox rounds over one counter block
    function phx_pkg::t_words philox_rounds(input logic [phx_pkg::HALF_W-1:0] lo,
                                            input logic [phx_pkg::HALF_W-1:0] hi);
        phx_pkg::t_words             v;
        logic [phx_pkg::WORD_W-1:0]  kx;
        logic [phx_pkg::WORD_W-1:0]  ky;
        logic [2*phx_pkg::WORD_W-1:0] px;
        logic [2*phx_pkg::WORD_W-1:0] pz;
        kx  = key_copy[31:0];
        ky  = key_copy[63:32];
        v.x = lo[31:0];
        v.y = lo[63:32];
        v.z = hi[31:0];
        v.w = hi[63:32];
        for (int r = 0; r < phx_pkg::ROUND_COUNT; r++) begin
            if (r > 0) begin
                kx = kx + phx_pkg::WEYL_KX;
                ky = ky + phx_pkg::WEYL_KY;
            end
            px = {32'b0, phx_pkg::MUL_X} * {32'b0, v.x};
            pz = {32'b0, phx_pkg::MUL_Z} * {32'b0, v.z};
            v  = '{x: pz[63:32] ^ v.y ^ kx, y: pz[31:0],
                   z: px[63:32] ^ v.w ^ ky, w: px[31:0]};
        end
        return v;
    endfunction

    function void note_counter(input logic [phx_pkg::HALF_W-1:0] lo,
                               input logic [phx_pkg::HALF_W-1:0] hi);
        expected_blocks.push_back(philox_rounds(lo, hi));
        counters_seen++;
    endfunction

    function void check_block(input phx_pkg::t_words got);
        phx_pkg::t_words want;
        if (expected_blocks.size() == 0) begin
            $error("block item with no counter pending: %h %h %h %h",
                   got.x, got.y, got.z, got.w);
            mismatches++;
            return;
        end
        want = expected_blocks.pop_front();
        blocks_checked++;
        if (got.x !== want.x) begin
            $error("word0 mismatch: expected %h, actual %h", want.x, got.x);
            mismatches++;
        end
        if (got.y !== want.y) begin
            $error("word1 mismatch: expected %h, actual %h", want.y, got.y);
            mismatches++;
        end
        if (got.z !== want.z) begin
            $error("word2 mismatch: expected %h, actual %h", want.z, got.z);
            mismatches++;
        end
        if (got.w !== want.w) begin
            $error("word3 mismatch: expected %h, actual %h", want.w, got.w);
            mismatches++;
        end
    endfunction

    function int unsigned pending();
        return expected_blocks.size();
    endfunction
endclass

module philox4x32_10_block_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import phx_pkg::*;

    localparam int unsigned RANDOM_ITEMS_PER_PHASE = 434;
    localparam int unsigned STALL_LIMIT            = 2000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_seed_key_we;
    logic [HALF_W-1:0]   i_seed_key;

    phx_ctr_if ctr_if();
    phx_blk_if blk_if();

    // idle odds in percent, changed per phase by the main sequence
    int unsigned src_idle_pct = 14;
    int unsigned snk_idle_pct = 70;
    int unsigned key_writes   = 0;

    philox_block_scoreboard sb = new;

    philox4x32_10_block_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_key_we (i_seed_key_we),
        .i_seed_key    (i_seed_key),
        .i_counter     (ctr_if),
        .o_block       (blk_if)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // both channels sampled at the edge, before any update lands
    always @(posedge i_clk) begin
        if (ctr_if.valid && ctr_if.ready)
            sb.note_counter(ctr_if.counter_low, ctr_if.counter_high);
        if (blk_if.valid && blk_if.ready)
            sb.check_block('{x: blk_if.word0, y: blk_if.word1,
                             z: blk_if.word2, w: blk_if.word3});
    end

    // receiver: random back-pressure at the current odds
    initial begin
        blk_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            blk_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog: too long without any item moving on either side
    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((ctr_if.valid && ctr_if.ready) || (blk_if.valid && blk_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("philox4x32_10_block_generator_tb: FAIL");
        $finish;
    end

    // present one counter item, with random gaps first, and hold it until taken
    task automatic send_counter(input logic [HALF_W-1:0] lo, input logic [HALF_W-1:0] hi);
        while ($urandom_range(99) < src_idle_pct) begin
            ctr_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        ctr_if.valid        <= 1'b1;
        ctr_if.counter_low  <= lo;
        ctr_if.counter_high <= hi;
        do
            @(posedge i_clk);
        while (!ctr_if.ready);
    endtask

    // key changes only with the pipe empty: drain, let the stages settle, write
    task automatic load_seed_key(input logic [HALF_W-1:0] k);
        ctr_if.valid <= 1'b0;
        // wait for the edge that puts the last accepted counter into the scoreboard
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (ROUND_COUNT) @(posedge i_clk);
        i_seed_key_we <= 1'b1;
        i_seed_key    <= k;
        @(posedge i_clk);
        i_seed_key_we <= 1'b0;
        sb.set_key(k);
        key_writes++;
    endtask

    // mostly full random halves, with zeros, ones and single-bit patterns mixed in
    function automatic logic [HALF_W-1:0] pick_counter_half();
        logic [HALF_W-1:0] one_bit;
        one_bit = 64'h1 << $urandom_range(63);
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2:       return one_bit;
            3:       return ~one_bit;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        i_rst_n             <= 1'b0;
        i_seed_key_we       <= 1'b0;
        i_seed_key          <= '0;
        ctr_if.valid        <= 1'b0;
        ctr_if.counter_low  <= '0;
        ctr_if.counter_high <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: key still at its reset value of zero
        send_counter('0, '0);
        send_counter('1, '1);
        send_counter(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_counter(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_counter(64'h0000_0000_0000_0001, '0);
        send_counter('0, 64'h8000_0000_0000_0000);
        // each counter word alone at all ones
        send_counter(64'h0000_0000_FFFF_FFFF, '0);
        send_counter(64'hFFFF_FFFF_0000_0000, '0);
        send_counter('0, 64'h0000_0000_FFFF_FFFF);
        send_counter('0, 64'hFFFF_FFFF_0000_0000);

        // all-ones key: both key halves wrap on the first weyl add
        load_seed_key('1);
        send_counter('0, '0);
        send_counter('1, '1);
        send_counter(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);

        // one key half at a time
        load_seed_key(64'h0000_0000_FFFF_FFFF);
        send_counter('0, '0);
        send_counter(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        load_seed_key(64'hFFFF_FFFF_0000_0000);
        send_counter('0, '0);

        // random phases: sender light / receiver heavy, then swapped, then no idling
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 14;
                    snk_idle_pct = 70;
                    load_seed_key({$urandom, $urandom});
                end
                1: begin
                    src_idle_pct = 70;
                    snk_idle_pct = 14;
                    load_seed_key('0);
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    load_seed_key({$urandom, $urandom});
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
                // fresh random key halfway through each phase
                if (n == RANDOM_ITEMS_PER_PHASE / 2)
                    load_seed_key({$urandom, $urandom});
                send_counter(pick_counter_half(), pick_counter_half());
            end
        end
        ctr_if.valid <= 1'b0;
        @(posedge i_clk);

        // drain, then wait on to catch any stray block item
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (ROUND_COUNT + 5) @(posedge i_clk);

        $display("run covered %0d counter items and %0d checked blocks over %0d key settings,",
                 sb.counters_seen, sb.blocks_checked, key_writes + 1);
        $display("with idling on the sender, on the receiver, and on neither; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("philox4x32_10_block_generator_tb: PASS");
        end else begin
            $display("philox4x32_10_block_generator_tb: FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/phx_pkg.sv
design/phx_if.sv
design/phx_round.sv
design/philox4x32_10_block_generator.sv
tb/philox4x32_10_block_generator_tb.sv
